FILE: hw/rtl/huffman_code_builder_unit_macros.svh
// Assertion macros for the Huffman code builder checker.
// Both sample on clk and are disabled while arst_n is low.
`ifndef HUFFMAN_CODE_BUILDER_UNIT_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define HCB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HCB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared sizes, store entry types and the controller to datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

	localparam int SYM_MAX  = 16;
	localparam int NODE_N   = 2 * SYM_MAX - 1;
	localparam int NIDX_W   = $clog2(NODE_N);
	localparam int HIDX_W   = $clog2(SYM_MAX);
	localparam int CNT_W    = $clog2(SYM_MAX + 1);
	localparam int SYMB_W   = 8;
	localparam int FREQ_W   = 24;
	localparam int WGT_W    = 30;
	localparam int CODE_W   = SYM_MAX - 1;
	localparam int LEN_W    = $clog2(SYM_MAX);
	localparam int OBITS_W  = 63;
	localparam int OLEN_W   = 6;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 80;
	localparam int M_PAD_W  = M_DATA_W - SYMB_W - OBITS_W - OLEN_W;

	typedef struct packed {
		logic [WGT_W-1:0]  w;
		logic [NIDX_W-1:0] n;
	} hent_t;

	typedef struct packed {
		logic              leaf;
		logic [SYMB_W-1:0] sym;
		logic [NIDX_W-1:0] lft;
		logic [NIDX_W-1:0] rgt;
	} node_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_HF_RD,
		OP_HF_CUR,
		OP_HF_NEXT,
		OP_SD_RDL,
		OP_SD_PUT,
		OP_SD_CMPL,
		OP_SD_CMPR,
		OP_SD_STEP,
		OP_TM_RD0,
		OP_TM_TOPA,
		OP_TM_TOPB,
		OP_TM_LAST,
		OP_MERGE,
		OP_SU_RD,
		OP_SU_PUT,
		OP_SU_CMP,
		OP_ROOT,
		OP_W_POP,
		OP_W_NODE,
		OP_W_END
	} op_t;

	typedef struct packed {
		op_t  op;
		logic in_rdy;
	} cmd_t;

	typedef struct packed {
		logic l_ok;
		logic r_ok;
		logic sd_stop;
		logic k_zero;
		logic multi;
		logic pos_zero;
		logic su_stop;
		logic sp_zero;
		logic w_stall;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/huffman_code_builder_unit.sv
// ----------------------------------------------------------------------------
// huffman_code_builder_unit
// Builds a Huffman code over a run of (symbol, frequency) words.
// ----------------------------------------------------------------------------
// Symbol words load one per cycle; up to 16 are kept, later ones in the run
// are dropped. The word with tlast starts the build: a bottom-up heapify,
// then n-1 merges of the two lightest nodes, then a depth-first walk that
// emits one code word per leaf, left (0) before right (1), tlast on the final
// one. Input is stalled from the last word until the final code word is
// handed to the output register. Every heap read goes through the single
// read port of the heap RAM, so a sift-down level steps through read-left,
// compare-left, an optional compare-right and step states, and a sift-up
// level through read and compare states; the walk takes each tree node
// through check, pop and node states and waits on output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder_unit
	import hcb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // symbol[7:0], frequency[31:8]
	input  wire logic                s_axis_tlast,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic      [M_DATA_W-1:0] m_axis_tdata,  // code_symbol, code_bits, code_length, pad
	output logic                     m_axis_tlast
);

	cmd_t cmd;
	sts_t sts;

	hcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.sts      (sts),
		.cmd      (cmd)
	);

	hcb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_sym    (s_axis_tdata[SYMB_W-1:0]),
		.in_freq   (s_axis_tdata[SYMB_W+FREQ_W-1:SYMB_W]),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_last  (m_axis_tlast),
		.out_data  (m_axis_tdata)
	);

	assign s_axis_tready = cmd.in_rdy;

endmodule

`default_nettype wire

FILE: hw/rtl/hcb_ram.sv
// ----------------------------------------------------------------------------
// hcb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/hcb_ctrl.sv
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer: load, heapify, extract/merge/sift-up loop, then tree walk.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ctrl
	import hcb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_last,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [20:0] {
		ST_IDLE    = 21'h000001,
		ST_HF_RD   = 21'h000002,
		ST_HF_CUR  = 21'h000004,
		ST_SD_L    = 21'h000008,
		ST_SD_CL   = 21'h000010,
		ST_SD_CR   = 21'h000020,
		ST_SD_ST   = 21'h000040,
		ST_HF_NX   = 21'h000080,
		ST_BLD     = 21'h000100,
		ST_TM_RD   = 21'h000200,
		ST_TM_TOP  = 21'h000400,
		ST_TM_LAST = 21'h000800,
		ST_MERGE   = 21'h001000,
		ST_SU      = 21'h002000,
		ST_SU_CMP  = 21'h004000,
		ST_RT_RD   = 21'h008000,
		ST_RT      = 21'h010000,
		ST_W_CHK   = 21'h020000,
		ST_W_POP   = 21'h040000,
		ST_W_NODE  = 21'h080000,
		ST_W_END   = 21'h100000
	} state_t;

	// where a sift-down returns to
	typedef enum logic [2:0] {
		RET_HF = 3'b001,
		RET_A  = 3'b010,
		RET_B  = 3'b100
	} ret_t;

	state_t st_q, st_d;
	ret_t   ret_q, ret_d;
	logic   tb_q, tb_d;
	state_t ret_st;
	op_t    op;

	always_comb begin
		case (ret_q)
			RET_HF:  ret_st = ST_HF_NX;
			RET_A:   ret_st = ST_TM_RD;
			RET_B:   ret_st = ST_MERGE;
			default: ret_st = ST_HF_NX;
		endcase
	end

	always_comb begin
		st_d  = st_q;
		ret_d = ret_q;
		tb_d  = tb_q;
		op    = OP_NONE;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					op = OP_LOAD;
					if (in_last) begin
						st_d = ST_HF_RD;
					end
				end
			end
			ST_HF_RD: begin
				op   = OP_HF_RD;
				st_d = ST_HF_CUR;
			end
			ST_HF_CUR: begin
				op    = OP_HF_CUR;
				ret_d = RET_HF;
				st_d  = ST_SD_L;
			end
			ST_SD_L: begin
				if (sts.l_ok) begin
					op   = OP_SD_RDL;
					st_d = ST_SD_CL;
				end else begin
					op   = OP_SD_PUT;
					st_d = ret_st;
				end
			end
			ST_SD_CL: begin
				op   = OP_SD_CMPL;
				st_d = sts.r_ok ? ST_SD_CR : ST_SD_ST;
			end
			ST_SD_CR: begin
				op   = OP_SD_CMPR;
				st_d = ST_SD_ST;
			end
			ST_SD_ST: begin
				op   = OP_SD_STEP;
				st_d = sts.sd_stop ? ret_st : ST_SD_L;
			end
			ST_HF_NX: begin
				if (sts.k_zero) begin
					st_d = ST_BLD;
				end else begin
					op   = OP_HF_NEXT;
					st_d = ST_HF_RD;
				end
			end
			ST_BLD: begin
				tb_d = 1'b0;
				st_d = sts.multi ? ST_TM_RD : ST_RT_RD;
			end
			ST_TM_RD: begin
				op   = OP_TM_RD0;
				st_d = ST_TM_TOP;
			end
			ST_TM_TOP: begin
				op   = tb_q ? OP_TM_TOPB : OP_TM_TOPA;
				st_d = ST_TM_LAST;
			end
			ST_TM_LAST: begin
				op    = OP_TM_LAST;
				ret_d = tb_q ? RET_B : RET_A;
				tb_d  = 1'b1;
				st_d  = ST_SD_L;
			end
			ST_MERGE: begin
				op   = OP_MERGE;
				st_d = ST_SU;
			end
			ST_SU: begin
				if (sts.pos_zero) begin
					op   = OP_SU_PUT;
					st_d = ST_BLD;
				end else begin
					op   = OP_SU_RD;
					st_d = ST_SU_CMP;
				end
			end
			ST_SU_CMP: begin
				op   = OP_SU_CMP;
				st_d = sts.su_stop ? ST_BLD : ST_SU;
			end
			ST_RT_RD: begin
				op   = OP_TM_RD0;
				st_d = ST_RT;
			end
			ST_RT: begin
				op   = OP_ROOT;
				st_d = ST_W_CHK;
			end
			ST_W_CHK: begin
				st_d = sts.sp_zero ? ST_W_END : ST_W_POP;
			end
			ST_W_POP: begin
				op   = OP_W_POP;
				st_d = ST_W_NODE;
			end
			ST_W_NODE: begin
				op = OP_W_NODE;
				if (!sts.w_stall) begin
					st_d = ST_W_CHK;
				end
			end
			ST_W_END: begin
				op = OP_W_END;
				if (sts.out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			ret_q <= RET_HF;
			tb_q  <= 1'b0;
		end else begin
			st_q  <= st_d;
			ret_q <= ret_d;
			tb_q  <= tb_d;
		end
	end

	assign cmd.op     = op;
	assign cmd.in_rdy = (st_q == ST_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/hcb_dp.sv
// ----------------------------------------------------------------------------
// hcb_dp
// Datapath: heap and node stores, sift registers, walk stack, output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_dp
	import hcb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	input  wire logic [SYMB_W-1:0]   in_sym,
	input  wire logic [FREQ_W-1:0]   in_freq,
	input  wire logic                out_ready,
	output sts_t                     sts,
	output logic                     out_valid,
	output logic                     out_last,
	output logic      [M_DATA_W-1:0] out_data
);

	typedef struct packed {
		logic [NIDX_W-1:0] node;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} stk_t;

	typedef struct packed {
		logic [SYMB_W-1:0] sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} res_t;

	// control state
	logic [CNT_W-1:0] ld_q, cnt_q, sp_q;
	logic             hold_v_q, out_v_q;
	// payload
	logic [HIDX_W-1:0] k_q, pos_q, bidx_q;
	logic [NIDX_W-1:0] nxt_q, nad_q;
	hent_t             cur_q, bst_q, a_q, b_q, new_q;
	logic [CODE_W-1:0] pre_q;
	logic [LEN_W-1:0]  len_q;
	stk_t              stk_q [SYM_MAX];
	res_t              hold_q, out_q;
	logic              last_q;

	logic                h_we;
	logic [HIDX_W-1:0]   h_waddr, h_raddr;
	hent_t               h_wdata, hrd;
	logic                n_we;
	logic [NIDX_W-1:0]   n_waddr, n_raddr;
	node_t               n_wdata, nrd;

	logic [HIDX_W+1:0]   l_idx, r_idx;
	logic [HIDX_W-1:0]   par, cnt_m1, sp_top;
	logic                ld_lt, su_less, out_free, hold_load, out_set;
	logic [CNT_W-1:0]    ld_n;
	stk_t                top_e;

	assign l_idx    = {1'b0, pos_q, 1'b1};
	assign r_idx    = l_idx + (HIDX_W+2)'(1);
	assign par      = (pos_q - HIDX_W'(1)) >> 1;
	assign cnt_m1   = HIDX_W'(cnt_q - CNT_W'(1));
	assign sp_top   = HIDX_W'(sp_q - CNT_W'(1));
	assign top_e    = stk_q[sp_top];
	assign ld_lt    = (ld_q < CNT_W'(SYM_MAX));
	assign ld_n     = ld_lt ? ld_q + CNT_W'(1) : ld_q;
	assign su_less  = (new_q.w < hrd.w);
	assign out_free = !out_v_q || out_ready;

	assign sts.l_ok     = (l_idx < (HIDX_W+2)'(cnt_q));
	assign sts.r_ok     = (r_idx < (HIDX_W+2)'(cnt_q));
	assign sts.sd_stop  = (bidx_q == pos_q);
	assign sts.k_zero   = (k_q == '0);
	assign sts.multi    = (cnt_q > CNT_W'(1));
	assign sts.pos_zero = (pos_q == '0);
	assign sts.su_stop  = !su_less;
	assign sts.sp_zero  = (sp_q == '0);
	assign sts.w_stall  = nrd.leaf && hold_v_q && !out_free;
	assign sts.out_free = out_free;

	assign hold_load = (cmd.op == OP_W_NODE) && nrd.leaf && !(hold_v_q && !out_free);
	// a word enters the output register
	assign out_set   = (hold_load && hold_v_q) || ((cmd.op == OP_W_END) && out_free);

	always_comb begin
		h_we    = 1'b0;
		h_waddr = pos_q;
		h_wdata = cur_q;
		h_raddr = k_q;
		n_we    = 1'b0;
		n_waddr = nxt_q;
		n_wdata = '{leaf: 1'b0, sym: '0, lft: a_q.n, rgt: b_q.n};
		n_raddr = nad_q;
		case (cmd.op)
			OP_LOAD: begin
				h_we    = ld_lt;
				h_waddr = ld_q[HIDX_W-1:0];
				h_wdata = '{w: WGT_W'(in_freq), n: NIDX_W'(ld_q)};
				n_we    = ld_lt;
				n_waddr = NIDX_W'(ld_q);
				n_wdata = '{leaf: 1'b1, sym: in_sym, lft: '0, rgt: '0};
			end
			OP_SD_RDL:  h_raddr = l_idx[HIDX_W-1:0];
			OP_SD_CMPL: h_raddr = r_idx[HIDX_W-1:0];
			OP_SD_PUT:  h_we = 1'b1;
			OP_SD_STEP: begin
				h_we    = 1'b1;
				h_wdata = sts.sd_stop ? cur_q : bst_q;
			end
			OP_TM_RD0:  h_raddr = '0;
			OP_TM_TOPA: h_raddr = cnt_m1;
			OP_TM_TOPB: h_raddr = cnt_m1;
			OP_MERGE:   n_we = 1'b1;
			OP_SU_RD:   h_raddr = par;
			OP_SU_PUT: begin
				h_we    = 1'b1;
				h_wdata = new_q;
			end
			OP_SU_CMP: begin
				h_we    = 1'b1;
				h_wdata = su_less ? hrd : new_q;
			end
			OP_W_POP:   n_raddr = top_e.node;
			default: ;
		endcase
	end

	hcb_ram #(.WIDTH($bits(hent_t)), .DEPTH(SYM_MAX)) u_heap (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (hrd)
	);

	hcb_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_N)) u_node (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (n_raddr),
		.rdata (nrd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q     <= '0;
			cnt_q    <= '0;
			sp_q     <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_set) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: begin
					ld_q  <= ld_n;
					cnt_q <= ld_n;
				end
				OP_TM_LAST: cnt_q <= cnt_q - CNT_W'(1);
				OP_MERGE:   cnt_q <= cnt_q + CNT_W'(1);
				OP_ROOT: begin
					cnt_q    <= '0;
					sp_q     <= CNT_W'(1);
					hold_v_q <= 1'b0;
				end
				OP_W_POP: sp_q <= sp_q - CNT_W'(1);
				OP_W_NODE: begin
					if (hold_load) begin
						hold_v_q <= 1'b1;
					end else if (!nrd.leaf && sp_q <= CNT_W'(SYM_MAX - 2)) begin
						sp_q <= sp_q + CNT_W'(2);
					end
				end
				OP_W_END: begin
					if (out_free) begin
						hold_v_q <= 1'b0;
						ld_q     <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				k_q   <= HIDX_W'(ld_n >> 1);
				nxt_q <= NIDX_W'(ld_n);
			end
			OP_HF_CUR: begin
				cur_q <= hrd;
				pos_q <= k_q;
			end
			OP_HF_NEXT: k_q <= k_q - HIDX_W'(1);
			OP_SD_CMPL: begin
				if (hrd.w < cur_q.w) begin
					bst_q  <= hrd;
					bidx_q <= l_idx[HIDX_W-1:0];
				end else begin
					bst_q  <= cur_q;
					bidx_q <= pos_q;
				end
			end
			OP_SD_CMPR: begin
				if (hrd.w < bst_q.w) begin
					bst_q  <= hrd;
					bidx_q <= r_idx[HIDX_W-1:0];
				end
			end
			OP_SD_STEP: pos_q <= bidx_q;
			OP_TM_TOPA: a_q <= hrd;
			OP_TM_TOPB: b_q <= hrd;
			OP_TM_LAST: begin
				cur_q <= hrd;
				pos_q <= '0;
			end
			OP_MERGE: begin
				new_q <= '{w: a_q.w + b_q.w, n: nxt_q};
				pos_q <= cnt_q[HIDX_W-1:0];
				nxt_q <= nxt_q + NIDX_W'(1);
			end
			OP_SU_CMP: begin
				if (su_less) begin
					pos_q <= par;
				end
			end
			OP_ROOT: stk_q[0] <= '{node: hrd.n, code: '0, len: '0};
			OP_W_POP: begin
				pre_q <= top_e.code;
				len_q <= top_e.len;
				nad_q <= top_e.node;
			end
			OP_W_NODE: begin
				if (hold_load) begin
					hold_q <= '{sym: nrd.sym, code: pre_q, len: len_q};
					if (hold_v_q) begin
						out_q  <= hold_q;
						last_q <= 1'b0;
					end
				end else if (!nrd.leaf && sp_q <= CNT_W'(SYM_MAX - 2)) begin
					// right is pushed below left so left pops first
					stk_q[sp_q[HIDX_W-1:0]] <=
						'{node: nrd.rgt, code: {pre_q[CODE_W-2:0], 1'b1}, len: len_q + LEN_W'(1)};
					stk_q[HIDX_W'(sp_q + CNT_W'(1))] <=
						'{node: nrd.lft, code: {pre_q[CODE_W-2:0], 1'b0}, len: len_q + LEN_W'(1)};
				end
			end
			OP_W_END: begin
				if (out_free) begin
					out_q  <= hold_q;
					last_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_v_q;
	assign out_last  = last_q;
	assign out_data  = {{M_PAD_W{1'b0}}, OLEN_W'(out_q.len), OBITS_W'(out_q.code), out_q.sym};

endmodule

`default_nettype wire

FILE: hw/rtl/hcb_chk.sv
// ----------------------------------------------------------------------------
// hcb_chk
// Port-level checks on the code builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_code_builder_unit_macros.svh"

module hcb_chk
	import hcb_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_axis_tvalid,
	input wire logic                s_axis_tready,
	input wire logic                s_axis_tlast,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	input wire logic [M_DATA_W-1:0] m_axis_tdata,
	input wire logic                m_axis_tlast
);

	// a stalled result word holds
	`HCB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result word changed under stall")

	// the closing word of a run blocks input while the tree is built
	`HCB_ASSERT_NEXT(a_build_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input taken during build")

	// no code bits above the code length, no pad bits
	`HCB_ASSERT_NOW(a_code_fit, m_axis_tvalid, ((m_axis_tdata[70:8] >> m_axis_tdata[76:71]) == 63'd0) && (m_axis_tdata[79:77] == 3'd0), "code bits beyond length")

endmodule

bind huffman_code_builder_unit hcb_chk u_chk (.*);

`default_nettype wire
